// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/lkdd_pkg.sv -----
`default_nettype none

package lkdd_pkg;

  // default geometry
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned DIR_LEVELS_DEF  = 4;
  localparam int unsigned BTN_LEVELS_DEF  = 2;

  // result field widths
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned DIR_CODE_W = 3;
  localparam int unsigned BTN_CODE_W = 2;
  localparam int unsigned DIR_IDX_W  = DIR_CODE_W - 1;
  localparam int unsigned BTN_IDX_W  = BTN_CODE_W - 1;

  // no key codes, all ones in two's complement
  localparam logic [CODE_W-1:0]     NO_KEY     = '1;
  localparam logic [DIR_CODE_W-1:0] NO_DIR     = '1;
  localparam logic [BTN_CODE_W-1:0] NO_BTN     = '1;
  // buttons start after the eight direction codes
  localparam logic [CODE_W-1:0]     BTN_BASE   = CODE_W'(8);

  // configuration
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(26);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned REG_LSB    = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CARDINAL  = 3'd0,
    REG_DIAGONAL  = 3'd1,
    REG_BUTTON    = 3'd2,
    REG_TOLERANCE = 3'd3,
    REG_LIMIT     = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// ----- sv/lkdd_if.sv -----
`default_nettype none

// poll channel: one set of ladder samples
interface lkdd_in_if #(
  parameter int unsigned SampleBits = lkdd_pkg::SAMPLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] cardinal_sample;
  logic [SampleBits-1:0] diagonal_sample;
  logic [SampleBits-1:0] button_sample;

  modport source (output valid, output cardinal_sample, output diagonal_sample,
                  output button_sample, input ready);
  modport sink   (input valid, input cardinal_sample, input diagonal_sample,
                  input button_sample, output ready);
endinterface

// result channel: decoded codes and press flag
interface lkdd_out_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      pressed;
  logic signed [lkdd_pkg::CODE_W-1:0]        combined_code;
  logic signed [lkdd_pkg::DIR_CODE_W-1:0]    cardinal_code;
  logic signed [lkdd_pkg::DIR_CODE_W-1:0]    diagonal_code;
  logic signed [lkdd_pkg::BTN_CODE_W-1:0]    button_code;

  modport source (output valid, output pressed, output combined_code,
                  output cardinal_code, output diagonal_code, output button_code,
                  input ready);
  modport sink   (input valid, input pressed, input combined_code,
                  input cardinal_code, input diagonal_code, input button_code,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/ladder_keypad_decode_debounce.sv -----
`default_nettype none

// Resistor ladder keypad decoder with debounce. Each transfer on in_i carries one poll of
// three ADC samples (cardinal, diagonal and option button ladders); each poll gives exactly
// one transfer on out_o with the matched level of every ladder (-1 for none, the highest
// matching level wins), the priority combined code (cardinal*2, else diagonal*2+1, else
// button+8, else -1) and a pressed flag raised when the debounce logic accepts a new stable
// code other than -1. One poll is taken per clock cycle while out_o is not stalled; it
// passes the input register, then the result register, and out_o back-pressure stalls both
// stages. The match windows are level +/- ((level*tolerance)>>8), worked out from the
// level and tolerance registers into a bounds register, so a register write is seen by
// polls taken from the cycle after the write onward. Registers sit on the APB port at
// byte address 8*index: cardinal levels, diagonal levels, button levels, tolerance and
// debounce limit; pready is always high and writes to other addresses are ignored.

`include "assert_macros.svh"

module ladder_keypad_decode_debounce #(
  parameter int unsigned SAMPLE_BITS      = lkdd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DIRECTION_LEVELS = lkdd_pkg::DIR_LEVELS_DEF,
  parameter int unsigned BUTTON_LEVELS    = lkdd_pkg::BTN_LEVELS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  lkdd_in_if.sink                          in_i,
  lkdd_out_if.source                       out_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [lkdd_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire [lkdd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lkdd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned DirW  = DIRECTION_LEVELS * SAMPLE_BITS;
  localparam int unsigned BtnW  = BUTTON_LEVELS * SAMPLE_BITS;
  localparam int unsigned ProdW = SAMPLE_BITS + lkdd_pkg::TOL_W;
  localparam int unsigned HiW   = SAMPLE_BITS + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DirW-1:0]               card_levels_q;
  logic [DirW-1:0]               diag_levels_q;
  logic [BtnW-1:0]               btn_levels_q;
  logic [lkdd_pkg::TOL_W-1:0]    tol_q;
  logic [lkdd_pkg::CNT_W-1:0]    limit_q;

  lkdd_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  assign reg_idx = lkdd_pkg::reg_idx_e'(paddr[lkdd_pkg::APB_ADDR_W-1:lkdd_pkg::REG_LSB]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_levels_q <= '0;
      diag_levels_q <= '0;
      btn_levels_q  <= '0;
      tol_q         <= lkdd_pkg::TOL_RESET;
      limit_q       <= lkdd_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lkdd_pkg::REG_CARDINAL:  card_levels_q <= pwdata[DirW-1:0];
        lkdd_pkg::REG_DIAGONAL:  diag_levels_q <= pwdata[DirW-1:0];
        lkdd_pkg::REG_BUTTON:    btn_levels_q  <= pwdata[BtnW-1:0];
        lkdd_pkg::REG_TOLERANCE: tol_q         <= pwdata[lkdd_pkg::TOL_W-1:0];
        lkdd_pkg::REG_LIMIT:     limit_q       <= pwdata[lkdd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      lkdd_pkg::REG_CARDINAL:  prdata = lkdd_pkg::APB_DATA_W'(card_levels_q);
      lkdd_pkg::REG_DIAGONAL:  prdata = lkdd_pkg::APB_DATA_W'(diag_levels_q);
      lkdd_pkg::REG_BUTTON:    prdata = lkdd_pkg::APB_DATA_W'(btn_levels_q);
      lkdd_pkg::REG_TOLERANCE: prdata = lkdd_pkg::APB_DATA_W'(tol_q);
      lkdd_pkg::REG_LIMIT:     prdata = lkdd_pkg::APB_DATA_W'(limit_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // window bounds: one small multiply per level, registered every cycle
  // lower bound never underflows as tolerance is below one, upper bound gets a carry bit
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] card_lo_d [DIRECTION_LEVELS];
  logic [HiW-1:0]         card_hi_d [DIRECTION_LEVELS];
  logic [SAMPLE_BITS-1:0] diag_lo_d [DIRECTION_LEVELS];
  logic [HiW-1:0]         diag_hi_d [DIRECTION_LEVELS];
  logic [SAMPLE_BITS-1:0] btn_lo_d  [BUTTON_LEVELS];
  logic [HiW-1:0]         btn_hi_d  [BUTTON_LEVELS];
  logic [SAMPLE_BITS-1:0] card_lo_q [DIRECTION_LEVELS];
  logic [HiW-1:0]         card_hi_q [DIRECTION_LEVELS];
  logic [SAMPLE_BITS-1:0] diag_lo_q [DIRECTION_LEVELS];
  logic [HiW-1:0]         diag_hi_q [DIRECTION_LEVELS];
  logic [SAMPLE_BITS-1:0] btn_lo_q  [BUTTON_LEVELS];
  logic [HiW-1:0]         btn_hi_q  [BUTTON_LEVELS];

  always_comb begin
    logic [SAMPLE_BITS-1:0] lvl;
    logic [ProdW-1:0]       prod;
    logic [SAMPLE_BITS-1:0] half;
    for (int i = 0; i < DIRECTION_LEVELS; i++) begin
      lvl          = card_levels_q[i*SAMPLE_BITS +: SAMPLE_BITS];
      prod         = ProdW'(lvl) * ProdW'(tol_q);
      half         = prod[ProdW-1:lkdd_pkg::TOL_W];
      card_lo_d[i] = lvl - half;
      card_hi_d[i] = HiW'(lvl) + HiW'(half);

      lvl          = diag_levels_q[i*SAMPLE_BITS +: SAMPLE_BITS];
      prod         = ProdW'(lvl) * ProdW'(tol_q);
      half         = prod[ProdW-1:lkdd_pkg::TOL_W];
      diag_lo_d[i] = lvl - half;
      diag_hi_d[i] = HiW'(lvl) + HiW'(half);
    end
    for (int i = 0; i < BUTTON_LEVELS; i++) begin
      lvl         = btn_levels_q[i*SAMPLE_BITS +: SAMPLE_BITS];
      prod        = ProdW'(lvl) * ProdW'(tol_q);
      half        = prod[ProdW-1:lkdd_pkg::TOL_W];
      btn_lo_d[i] = lvl - half;
      btn_hi_d[i] = HiW'(lvl) + HiW'(half);
    end
  end

  always_ff @(posedge clk_i) begin
    card_lo_q <= card_lo_d;
    card_hi_q <= card_hi_d;
    diag_lo_q <= diag_lo_d;
    diag_hi_q <= diag_hi_d;
    btn_lo_q  <= btn_lo_d;
    btn_hi_q  <= btn_hi_d;
  end

  // ---------------------------------------------------------------------------
  // handshake: input register then result register, each one deep
  // ---------------------------------------------------------------------------
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_card_q;
  logic [SAMPLE_BITS-1:0] s1_diag_q;
  logic [SAMPLE_BITS-1:0] s1_btn_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   in_take;

  // result register frees up when empty or when its transfer completes
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_card_q <= in_i.cardinal_sample;
      s1_diag_q <= in_i.diagonal_sample;
      s1_btn_q  <= in_i.button_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // window match, later levels override earlier ones
  // ---------------------------------------------------------------------------
  logic                           card_hit, diag_hit, btn_hit;
  logic [lkdd_pkg::DIR_IDX_W-1:0] card_idx, diag_idx;
  logic [lkdd_pkg::BTN_IDX_W-1:0] btn_idx;

  always_comb begin
    card_hit = 1'b0;
    diag_hit = 1'b0;
    btn_hit  = 1'b0;
    card_idx = '0;
    diag_idx = '0;
    btn_idx  = '0;
    for (int i = 0; i < DIRECTION_LEVELS; i++) begin
      if (s1_card_q >= card_lo_q[i] && HiW'(s1_card_q) <= card_hi_q[i]) begin
        card_hit = 1'b1;
        card_idx = lkdd_pkg::DIR_IDX_W'(i);
      end
      if (s1_diag_q >= diag_lo_q[i] && HiW'(s1_diag_q) <= diag_hi_q[i]) begin
        diag_hit = 1'b1;
        diag_idx = lkdd_pkg::DIR_IDX_W'(i);
      end
    end
    for (int i = 0; i < BUTTON_LEVELS; i++) begin
      if (s1_btn_q >= btn_lo_q[i] && HiW'(s1_btn_q) <= btn_hi_q[i]) begin
        btn_hit = 1'b1;
        btn_idx = lkdd_pkg::BTN_IDX_W'(i);
      end
    end
  end

  logic [lkdd_pkg::DIR_CODE_W-1:0] card_code_d, diag_code_d;
  logic [lkdd_pkg::BTN_CODE_W-1:0] btn_code_d;
  logic [lkdd_pkg::CODE_W-1:0]     code_d;

  assign card_code_d = card_hit ? {1'b0, card_idx} : lkdd_pkg::NO_DIR;
  assign diag_code_d = diag_hit ? {1'b0, diag_idx} : lkdd_pkg::NO_DIR;
  assign btn_code_d  = btn_hit  ? {1'b0, btn_idx}  : lkdd_pkg::NO_BTN;

  // cardinal even codes, diagonal odd codes, buttons from eight up
  always_comb begin
    priority if (card_hit) begin
      code_d = lkdd_pkg::CODE_W'({card_idx, 1'b0});
    end else if (diag_hit) begin
      code_d = lkdd_pkg::CODE_W'({diag_idx, 1'b1});
    end else if (btn_hit) begin
      code_d = lkdd_pkg::BTN_BASE | lkdd_pkg::CODE_W'(btn_idx);
    end else begin
      code_d = lkdd_pkg::NO_KEY;
    end
  end

  // ---------------------------------------------------------------------------
  // debounce: count repeats of the same code, saturating counter
  // ---------------------------------------------------------------------------
  logic [lkdd_pkg::CODE_W-1:0] prev_code_q, prev_code_d;
  logic [lkdd_pkg::CODE_W-1:0] stable_code_q, stable_code_d;
  logic [lkdd_pkg::CNT_W-1:0]  count_q, count_d;
  logic                        pressed_d;

  always_comb begin
    prev_code_d   = code_d;
    stable_code_d = stable_code_q;
    pressed_d     = 1'b0;
    if (code_d == prev_code_q) begin
      count_d = (count_q == '1) ? count_q : count_q + lkdd_pkg::CNT_W'(1);
      if (count_d >= limit_q && code_d != stable_code_q) begin
        stable_code_d = code_d;
        // going back to idle is accepted quietly
        pressed_d     = (code_d != lkdd_pkg::NO_KEY);
      end
    end else begin
      // a change restarts the count, no acceptance on this poll
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q   <= lkdd_pkg::NO_KEY;
      stable_code_q <= lkdd_pkg::NO_KEY;
      count_q       <= '0;
    end else if (advance) begin
      prev_code_q   <= prev_code_d;
      stable_code_q <= stable_code_d;
      count_q       <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic                            pressed_q;
  logic [lkdd_pkg::CODE_W-1:0]     code_q;
  logic [lkdd_pkg::DIR_CODE_W-1:0] card_code_q, diag_code_q;
  logic [lkdd_pkg::BTN_CODE_W-1:0] btn_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pressed_q   <= pressed_d;
      code_q      <= code_d;
      card_code_q <= card_code_d;
      diag_code_q <= diag_code_d;
      btn_code_q  <= btn_code_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pressed       = pressed_q;
  assign out_o.combined_code = code_q;
  assign out_o.cardinal_code = card_code_q;
  assign out_o.diagonal_code = diag_code_q;
  assign out_o.button_code   = btn_code_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS_CLK(a_rst_empty, clk_i, !rst_ni |=> !out_valid_q && !s1_valid_q,
    "pipeline not empty in reset")
  `ASSERT_CLK(a_press_not_idle, clk_i, rst_ni,
    out_valid_q && pressed_q |-> code_q != lkdd_pkg::NO_KEY, "press flagged on idle code")
  `ASSERT_CLK(a_card_priority, clk_i, rst_ni,
    out_valid_q && card_code_q != lkdd_pkg::NO_DIR |->
    code_q == lkdd_pkg::CODE_W'({card_code_q[lkdd_pkg::DIR_IDX_W-1:0], 1'b0}),
    "combined code ignores cardinal match")
  `ASSERT_CLK(a_change_restart, clk_i, rst_ni,
    advance && code_d != prev_code_q |=> count_q == '0, "count not restarted on change")
  `ASSERT_CLK(a_press_takes_code, clk_i, rst_ni,
    advance && pressed_d |=> stable_code_q == $past(code_d), "pressed code not made stable")

endmodule

`default_nettype wire
